// File: sv/mvd_pkg.sv
// ----------------------------------------------------------------------------
// MAVLink v1 deframer package
// Shared constants, parser phase encoding and the result word type.
// ----------------------------------------------------------------------------
package mvd_pkg;

  localparam logic [7:0] START_BYTE = 8'hFE;

  // Parser phases, one-hot.
  typedef enum logic [8:0] {
    PH_HUNT    = 9'b0_0000_0001,
    PH_LEN     = 9'b0_0000_0010,
    PH_SEQ     = 9'b0_0000_0100,
    PH_SYS     = 9'b0_0000_1000,
    PH_COMP    = 9'b0_0001_0000,
    PH_MSGID   = 9'b0_0010_0000,
    PH_PAYLOAD = 9'b0_0100_0000,
    PH_CRC1    = 9'b0_1000_0000,
    PH_CRC2    = 9'b1_0000_0000
  } mvd_phase_t;

  // One result word, as produced for every received byte.
  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_offset;
    logic [7:0] payload_byte;
    logic       frame_done;
    logic [7:0] msg_length;
    logic [7:0] seq_number;
    logic [7:0] system_id;
    logic [7:0] component_id;
    logic [7:0] message_id;
  } mvd_result_t;

endpackage

// File: sv/mvd_fsm.sv
// ----------------------------------------------------------------------------
// MAVLink v1 frame parser state machine
// Holds the parse phase and latched header, and builds the result word for
// the byte presented on rx_byte. State advances when step is high.
// ----------------------------------------------------------------------------
module mvd_fsm (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          rx_byte,
  output mvd_pkg::mvd_result_t result
);
  import mvd_pkg::*;

  mvd_phase_t phase_r, phase_nxt;
  logic [7:0] length_r, length_nxt;
  logic [7:0] seq_r, seq_nxt;
  logic [7:0] sysid_r, sysid_nxt;
  logic [7:0] compid_r, compid_nxt;
  logic [7:0] msgid_r, msgid_nxt;
  logic [7:0] count_r, count_nxt;
  logic [8:0] count_inc;

  assign count_inc = {1'b0, count_r} + 9'd1;

  always_comb begin
    phase_nxt  = phase_r;
    length_nxt = length_r;
    seq_nxt    = seq_r;
    sysid_nxt  = sysid_r;
    compid_nxt = compid_r;
    msgid_nxt  = msgid_r;
    count_nxt  = count_r;
    result     = '0;

    case (phase_r)
      PH_LEN: begin
        length_nxt = rx_byte;
        phase_nxt  = PH_SEQ;
      end
      PH_SEQ: begin
        seq_nxt   = rx_byte;
        phase_nxt = PH_SYS;
      end
      PH_SYS: begin
        sysid_nxt = rx_byte;
        phase_nxt = PH_COMP;
      end
      PH_COMP: begin
        compid_nxt = rx_byte;
        phase_nxt  = PH_MSGID;
      end
      PH_MSGID: begin
        msgid_nxt = rx_byte;
        count_nxt = '0;
        phase_nxt = (length_r != 8'd0) ? PH_PAYLOAD : PH_CRC1;
      end
      PH_PAYLOAD: begin
        if (count_r < length_r) begin
          result.payload_valid  = 1'b1;
          result.payload_offset = count_r;
          result.payload_byte   = rx_byte;
          count_nxt             = count_inc[7:0];
          if (count_inc >= {1'b0, length_r}) begin
            phase_nxt = PH_CRC1;
          end
        end else begin
          phase_nxt = PH_CRC1;
        end
      end
      PH_CRC1: begin
        phase_nxt = PH_CRC2;
      end
      PH_CRC2: begin
        result.frame_done   = 1'b1;
        result.msg_length   = length_r;
        result.seq_number   = seq_r;
        result.system_id    = sysid_r;
        result.component_id = compid_r;
        result.message_id   = msgid_r;
        phase_nxt           = PH_HUNT;
      end
      default: begin
        phase_nxt = (rx_byte == START_BYTE) ? PH_LEN : PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      length_r <= '0;
      seq_r    <= '0;
      sysid_r  <= '0;
      compid_r <= '0;
      msgid_r  <= '0;
      count_r  <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      length_r <= length_nxt;
      seq_r    <= seq_nxt;
      sysid_r  <= sysid_nxt;
      compid_r <= compid_nxt;
      msgid_r  <= msgid_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: sv/mavlink_v1_deframer.sv
// ----------------------------------------------------------------------------
// MAVLink v1 deframer
// Walks a MAVLink v1 byte stream and reports payload bytes and frame headers.
// ----------------------------------------------------------------------------
// Every accepted input word (one received byte) produces exactly one output
// word in the following cycle, and a new byte can be accepted in every cycle:
// the parser state machine and the output register form a single stage, and
// in_ready stays high as long as the output register is empty or is being
// drained in the same cycle. The parser hunts for the start byte 0xFE, then
// latches length, sequence, system id, component id and message id, passes
// each payload byte out with its index as it arrives, and skips the two
// checksum bytes without checking them. On the second checksum byte the
// output word carries frame_done together with the latched header fields;
// otherwise those header outputs read zero. Non-payload words carry zero in
// the payload fields. A started frame never aborts: a 0xFE inside a frame is
// ordinary data. Header values persist across frames until overwritten.
// ----------------------------------------------------------------------------
module mavlink_v1_deframer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_payload_valid,
  output logic [7:0] out_payload_offset,
  output logic [7:0] out_payload_byte,
  output logic       out_frame_done,
  output logic [7:0] out_msg_length,
  output logic [7:0] out_seq_number,
  output logic [7:0] out_system_id,
  output logic [7:0] out_component_id,
  output logic [7:0] out_message_id
);
  import mvd_pkg::*;

  logic        accept;
  logic        out_valid_r;
  mvd_result_t result;
  mvd_result_t result_r;

  // The output register may be refilled in the same cycle it is drained.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  mvd_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (accept),
    .rx_byte (in_rx_byte),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload register needs no reset; it is qualified by out_valid_r.
  always_ff @(posedge clk) begin
    if (accept) begin
      result_r <= result;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_payload_valid  = result_r.payload_valid;
  assign out_payload_offset = result_r.payload_offset;
  assign out_payload_byte   = result_r.payload_byte;
  assign out_frame_done     = result_r.frame_done;
  assign out_msg_length     = result_r.msg_length;
  assign out_seq_number     = result_r.seq_number;
  assign out_system_id      = result_r.system_id;
  assign out_component_id   = result_r.component_id;
  assign out_message_id     = result_r.message_id;

endmodule

// File: tb/mavlink_v1_deframer_tb.sv
// ----------------------------------------------------------------------------
// MAVLink v1 deframer testbench
// Feeds byte streams of whole frames and line noise into the
// deframer, predicts every output word with an independent parser model and
// compares the words field by field, under several sender and receiver paces.
// ----------------------------------------------------------------------------
module mavlink_v1_deframer_tb;

  import mvd_pkg::*;

  // Even with both sides idling at their worst, this leaves a wide margin
  // over the roughly 1700 bytes of the run.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_BYTES = 400;
  localparam int unsigned TAIL_CYCLES = 8;
  localparam int unsigned MAX_REPORTS = 100;

  // Handshake pacing used by the driver and the receiver side.
  typedef enum logic [1:0] {
    PACE_FREE,
    PACE_SEND_IDLE,
    PACE_RECV_STALL,
    PACE_BOTH
  } pace_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_payload_valid;
  logic [7:0] out_payload_offset;
  logic [7:0] out_payload_byte;
  logic       out_frame_done;
  logic [7:0] out_msg_length;
  logic [7:0] out_seq_number;
  logic [7:0] out_system_id;
  logic [7:0] out_component_id;
  logic [7:0] out_message_id;

  mavlink_v1_deframer uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_payload_valid  (out_payload_valid),
    .out_payload_offset (out_payload_offset),
    .out_payload_byte   (out_payload_byte),
    .out_frame_done     (out_frame_done),
    .out_msg_length     (out_msg_length),
    .out_seq_number     (out_seq_number),
    .out_system_id      (out_system_id),
    .out_component_id   (out_component_id),
    .out_message_id     (out_message_id)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bytes waiting to be offered, and the output words predicted for the bytes
  // that the block has already taken, oldest first.
  logic [7:0]  tx_bytes[$];
  mvd_result_t expected_words[$];

  pace_t       pace = PACE_FREE;
  bit          word_taken = 1'b0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  // Shadow copy of the parser state.
  mvd_phase_t  parse_state = PH_HUNT;
  logic [7:0]  hdr_length = 8'h00;
  logic [7:0]  hdr_seq = 8'h00;
  logic [7:0]  hdr_sysid = 8'h00;
  logic [7:0]  hdr_compid = 8'h00;
  logic [7:0]  hdr_msgid = 8'h00;
  logic [7:0]  payload_count = 8'h00;

  // Advances the shadow parser by one byte and returns the word the block
  // should emit for it. Header outputs are only nonzero on the word that
  // closes a frame; payload outputs only on payload bytes.
  function automatic mvd_result_t parse_byte(input logic [7:0] rx);
    mvd_result_t word;
    word = '0;
    case (parse_state)
      PH_LEN: begin
        hdr_length  = rx;
        parse_state = PH_SEQ;
      end
      PH_SEQ: begin
        hdr_seq     = rx;
        parse_state = PH_SYS;
      end
      PH_SYS: begin
        hdr_sysid   = rx;
        parse_state = PH_COMP;
      end
      PH_COMP: begin
        hdr_compid  = rx;
        parse_state = PH_MSGID;
      end
      PH_MSGID: begin
        hdr_msgid     = rx;
        payload_count = 8'h00;
        // An empty payload goes straight to the checksum bytes.
        parse_state   = (hdr_length != 8'h00) ? PH_PAYLOAD : PH_CRC1;
      end
      PH_PAYLOAD: begin
        if (payload_count < hdr_length) begin
          word.payload_valid  = 1'b1;
          word.payload_offset = payload_count;
          word.payload_byte   = rx;
          payload_count       = payload_count + 8'd1;
        end
        if (payload_count >= hdr_length) begin
          parse_state = PH_CRC1;
        end
      end
      PH_CRC1: begin
        parse_state = PH_CRC2;
      end
      PH_CRC2: begin
        // The checksum is never checked, so the frame is always delivered.
        word.frame_done   = 1'b1;
        word.msg_length   = hdr_length;
        word.seq_number   = hdr_seq;
        word.system_id    = hdr_sysid;
        word.component_id = hdr_compid;
        word.message_id   = hdr_msgid;
        parse_state       = PH_HUNT;
      end
      default: begin
        parse_state = (rx == START_BYTE) ? PH_LEN : PH_HUNT;
      end
    endcase
    return word;
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      if (error_count < MAX_REPORTS) begin
        $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
      end
      error_count++;
    end
  endtask

  // Queues one frame of the given length with random header fields and content.
  // The checksum bytes are random as well, since the block ignores them.
  task automatic add_frame(input logic [7:0] len);
    tx_bytes.push_back(START_BYTE);
    tx_bytes.push_back(len);
    repeat (4) tx_bytes.push_back(8'($urandom));
    repeat (len) tx_bytes.push_back(8'($urandom));
    repeat (2) tx_bytes.push_back(8'($urandom));
  endtask

  // Mostly short payloads keep the run quick; a few empty and full-length
  // frames hit the length extremes and the top payload index.
  function automatic logic [7:0] pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 3) begin
      return 8'hFF;
    end else if (r < 15) begin
      return 8'h00;
    end else if (r < 85) begin
      return 8'($urandom_range(12, 1));
    end else begin
      return 8'($urandom_range(80, 13));
    end
  endfunction

  // Fills the queue with about one phase worth of bytes: mostly well-formed
  // frames, with bursts of line noise in between. A noise byte that happens
  // to be 0xFE opens a frame out of garbage, which the block must follow too.
  task automatic add_random_stream();
    while (tx_bytes.size() < PHASE_BYTES) begin
      if ($urandom_range(99) < 85) begin
        add_frame(pick_length());
      end else begin
        repeat ($urandom_range(6, 1)) tx_bytes.push_back(8'($urandom));
      end
    end
  endtask

  function automatic bit sender_idles();
    case (pace)
      PACE_SEND_IDLE: return $urandom_range(99) < 80;
      PACE_BOTH:      return $urandom_range(99) < 12;
      default:        return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (pace)
      PACE_RECV_STALL: return $urandom_range(99) < 80;
      PACE_BOTH:       return $urandom_range(99) < 12;
      default:         return 1'b0;
    endcase
  endfunction

  // Everything is sampled at the rising edge, where the block's outputs still
  // hold their values from before the edge. A taken byte is predicted first,
  // so that the queue already holds its word should the block answer at once.
  always @(posedge clk) begin
    mvd_result_t exp_w;
    word_taken = 1'b0;
    if (rst_n && in_valid && in_ready) begin
      expected_words.push_back(parse_byte(in_rx_byte));
      void'(tx_bytes.pop_front());
      word_taken = 1'b1;
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        if (error_count < MAX_REPORTS) begin
          $error("output word with no prediction waiting");
        end
        error_count++;
      end else begin
        exp_w = expected_words.pop_front();
        check_field("payload_valid", {7'd0, exp_w.payload_valid},
                    {7'd0, out_payload_valid});
        check_field("payload_offset", exp_w.payload_offset, out_payload_offset);
        check_field("payload_byte", exp_w.payload_byte, out_payload_byte);
        check_field("frame_done", {7'd0, exp_w.frame_done},
                    {7'd0, out_frame_done});
        check_field("msg_length", exp_w.msg_length, out_msg_length);
        check_field("seq_number", exp_w.seq_number, out_seq_number);
        check_field("system_id", exp_w.system_id, out_system_id);
        check_field("component_id", exp_w.component_id, out_component_id);
        check_field("message_id", exp_w.message_id, out_message_id);
      end
    end
  end

  // The driver works at the falling edge. A word that was offered and not
  // taken stays on the bus unchanged; otherwise the next byte is offered
  // unless the sender chooses to idle. Each signal gets one assignment here.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!(in_valid && !word_taken)) begin
        if (tx_bytes.size() > 0 && !sender_idles()) begin
          in_valid   <= 1'b1;
          in_rx_byte <= tx_bytes[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= !receiver_stalls();
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("mavlink_v1_deframer_tb failed");
      $finish;
    end
  end

  // Waits until every queued byte has been taken and every predicted word has
  // come out. Returning here is also the point where the sender holds off
  // until the block has drained.
  task automatic drain();
    while (tx_bytes.size() != 0 || in_valid || expected_words.size() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Noise at both byte extremes, then an empty frame whose
    // checksum bytes are both 0xFE, then a two-byte frame that carries 0xFE
    // in its payload and whose header fields sit at 0x00 and 0xFF.
    pace = PACE_FREE;
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(8'hFF);
    tx_bytes.push_back(8'h55);
    tx_bytes.push_back(START_BYTE);
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(8'hFF);
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(8'hFF);
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(START_BYTE);
    tx_bytes.push_back(START_BYTE);
    tx_bytes.push_back(START_BYTE);
    tx_bytes.push_back(8'h02);
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(8'hFF);
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(8'hFF);
    tx_bytes.push_back(START_BYTE);
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(8'hFF);
    tx_bytes.push_back(8'h01);
    drain();

    // One full-length frame, so the top payload index is always reached.
    add_frame(8'hFF);
    add_random_stream();
    drain();

    pace = PACE_SEND_IDLE;
    add_random_stream();
    drain();

    pace = PACE_RECV_STALL;
    add_random_stream();
    drain();

    pace = PACE_BOTH;
    add_random_stream();
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_words.size() != 0) begin
      $error("%0d predicted words never came out", expected_words.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("mavlink_v1_deframer_tb passed");
    end else begin
      $display("mavlink_v1_deframer_tb failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/mvd_pkg.sv
sv/mvd_fsm.sv
sv/mavlink_v1_deframer.sv
tb/mavlink_v1_deframer_tb.sv
